// ===== design/plbl_pkg.sv =====
// Shared constants and types for the piecewise-linear BER lookup block.
package plbl_pkg;

  // Number of breakpoints the table can hold.
  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam logic [31:0] BER_ONE = 32'h8000_0000;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic [1:0] REGION_ABOVE  = 2'd0;
  localparam logic [1:0] REGION_INTERP = 2'd1;
  localparam logic [1:0] REGION_BELOW  = 2'd2;

  typedef struct packed {
    logic [31:0] sir;
    logic [31:0] ber;
    logic [31:0] slope;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_SEARCH,
    ST_FETCH,
    ST_MUL,
    ST_SUM
  } ctrl_state_t;

  typedef struct packed {
    logic             busy;
    logic             go;
    logic [1:0]       region;
    logic [IDX_W-1:0] sel;
  } ctrl_status_t;

endpackage

// ===== design/plbl_cell.sv =====
// One table cell: a breakpoint, its compare flag and one stage of the fetch chain.
module plbl_cell (
  input  logic            clk,
  input  logic            we,
  input  plbl_pkg::entry_t wdata,
  input  logic [31:0]     query_sir,
  input  logic            hit,
  input  plbl_pkg::entry_t chain_in,
  output logic            gt,
  output plbl_pkg::entry_t chain_out
);
  import plbl_pkg::*;

  entry_t entry_r;
  entry_t chain_r;
  logic   gt_r;

  always_ff @(posedge clk) begin
    if (we) begin
      entry_r <= wdata;
    end
    gt_r    <= query_sir > entry_r.sir;
    // The selected cell drops its own entry into the chain; the others pass it on.
    chain_r <= hit ? entry_r : chain_in;
  end

  assign gt        = gt_r;
  assign chain_out = chain_r;

endmodule

// ===== design/plbl_ctrl.sv =====
// Query sequencer: bisection over the cell flags, then fetch and arithmetic timing.
module plbl_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         query_go,
  input  logic [plbl_pkg::CNT_W-1:0]   n,
  input  logic [plbl_pkg::TABLE_DEPTH-1:0] gt,
  output plbl_pkg::ctrl_status_t       status
);
  import plbl_pkg::*;

  ctrl_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] a_r, a_nxt;
  logic [CNT_W-1:0] b_r, b_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       region_r, region_nxt;
  logic [IDX_W-1:0] sel_r, sel_nxt;
  logic             go_c;

  logic [CNT_W-1:0] mid;
  logic [IDX_W-1:0] mid_i, mid_m1, mid_p1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    cnt_r    <= cnt_nxt;
    region_r <= region_nxt;
    sel_r    <= sel_nxt;
  end

  assign mid    = CNT_W'((a_r + b_r) >> 1);
  assign mid_i  = mid[IDX_W-1:0];
  assign mid_m1 = mid_i - 1'b1;
  assign mid_p1 = mid_i + 1'b1;

  always_comb begin
    state_nxt  = state_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    cnt_nxt    = cnt_r;
    region_nxt = region_r;
    sel_nxt    = sel_r;
    go_c       = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (query_go) begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        a_nxt      = '0;
        b_nxt      = n;
        cnt_nxt    = '0;
        region_nxt = REGION_BELOW;
        if (n == '0) begin
          state_nxt = ST_MUL;
        end else begin
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (a_r >= b_r) begin
          region_nxt = REGION_BELOW;
          state_nxt  = ST_MUL;
        end else if (gt[mid_i]) begin
          if (mid == '0) begin
            region_nxt = REGION_ABOVE;
            sel_nxt    = '0;
            state_nxt  = ST_FETCH;
          end else if (gt[mid_m1]) begin
            b_nxt = mid;
          end else begin
            region_nxt = REGION_INTERP;
            sel_nxt    = mid_m1;
            state_nxt  = ST_FETCH;
          end
        end else if (mid == CNT_W'(n - 1'b1)) begin
          region_nxt = REGION_BELOW;
          state_nxt  = ST_MUL;
        end else if (gt[mid_p1]) begin
          region_nxt = REGION_INTERP;
          sel_nxt    = mid_i;
          state_nxt  = ST_FETCH;
        end else begin
          a_nxt = CNT_W'(mid + 1'b1);
        end
      end
      ST_FETCH: begin
        // The chain settles one cell per cycle; the tail is good after a full pass.
        cnt_nxt = CNT_W'(cnt_r + 1'b1);
        if (cnt_r == CNT_W'(TABLE_DEPTH - 1)) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        go_c      = 1'b1;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign status.go     = go_c;
  assign status.busy   = state_r != ST_IDLE;
  assign status.region = region_r;
  assign status.sel    = sel_r;

endmodule

// ===== design/plbl_interp.sv =====
// Interpolation datapath: one registered multiply, then add and saturate.
module plbl_interp (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  logic [1:0]       region,
  input  logic [31:0]      query_sir,
  input  plbl_pkg::entry_t entry,
  output logic             res_valid,
  output logic [31:0]      res_ber,
  output logic [1:0]       res_region
);
  import plbl_pkg::*;

  logic [31:0] diff;
  logic [31:0] slope;
  logic [31:0] base;
  logic [63:0] prod_r;
  logic [31:0] base_r;
  logic [1:0]  region_r;
  logic        v1_r;
  logic [63:0] sum;
  logic [31:0] ber_out_r;
  logic [1:0]  region_out_r;
  logic        valid_out_r;

  always_comb begin
    diff  = '0;
    slope = '0;
    base  = entry.ber;
    case (region)
      REGION_INTERP: begin
        diff  = entry.sir - query_sir;
        slope = entry.slope;
      end
      REGION_BELOW: begin
        base = BER_ONE;
      end
      default: begin
        base = entry.ber;
      end
    endcase
  end

  assign sum = {1'b0, prod_r[63:1]} + {32'b0, base_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      valid_out_r <= 1'b0;
    end else begin
      v1_r        <= go;
      valid_out_r <= v1_r;
    end
    prod_r       <= 64'(diff) * 64'(slope);
    base_r       <= base;
    region_r     <= region;
    ber_out_r    <= (sum > 64'(BER_ONE)) ? BER_ONE : sum[31:0];
    region_out_r <= region_r;
  end

  assign res_valid  = valid_out_r;
  assign res_ber    = ber_out_r;
  assign res_region = region_out_r;

endmodule

// ===== design/piecewise_linear_ber_lookup_core.sv =====
// Top level of the piecewise-linear BER lookup: cell row, sequencer and datapath.
//
//   Channel   Handshake                  Payload
//   input     start / busy               in_kind, in_entry_index, in_sir_value,
//                                        in_ber_value, in_slope_value
//   result    out_valid (one-cycle pulse) out_ber_out, out_region
//   config    cfg_valid / cfg_ready      cfg_entries_in_use
//
// A word on the input channel is taken at a rising edge with start high and busy low.
// A load word writes its cell at that edge and leaves the block idle, so loads go
// one per cycle. A query word passes through a compare step, bisection steps, the
// fetch chain carrying the chosen breakpoint to the tail, and the multiply and sum
// steps; the result pulse comes in the cycle after the sum step. A query that lands
// at or below the table bottom skips the fetch. The fetch chain length sets the
// query time. Reset is synchronous, active low; it clears the control state and
// the entry count, while table contents stay undefined. The result cannot be
// stalled; busy falls as the result is shown.
module piecewise_linear_ber_lookup_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_kind,
  input  logic [3:0]  in_entry_index,
  input  logic [31:0] in_sir_value,
  input  logic [31:0] in_ber_value,
  input  logic [31:0] in_slope_value,
  output logic        out_valid,
  output logic [31:0] out_ber_out,
  output logic [1:0]  out_region,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_entries_in_use
);
  import plbl_pkg::*;

  logic [4:0]             entries_r;
  logic [CNT_W-1:0]       n;
  logic [31:0]            sir_q_r;
  logic                   accept;
  logic                   query_go;
  ctrl_status_t           status;
  logic [TABLE_DEPTH-1:0] gt;
  entry_t                 wdata;
  entry_t                 chain [TABLE_DEPTH+1];

  assign accept   = start && !busy;
  assign query_go = accept && (in_kind == KIND_QUERY);

  // The entry count is clamped to the table size.
  assign n = (32'(entries_r) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH) : CNT_W'(entries_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      entries_r <= cfg_entries_in_use;
    end
    if (query_go) begin
      sir_q_r <= in_sir_value;
    end
  end

  assign wdata.sir   = in_sir_value;
  assign wdata.ber   = in_ber_value;
  assign wdata.slope = in_slope_value;

  // The head of the fetch chain carries nothing until the selected cell fills it.
  assign chain[0] = '0;

  for (genvar j = 0; j < TABLE_DEPTH; j++) begin : g_cell
    plbl_cell u_cell (
      .clk       (clk),
      .we        (accept && (in_kind == KIND_LOAD) && (32'(in_entry_index) == j)),
      .wdata     (wdata),
      .query_sir (sir_q_r),
      .hit       (32'(status.sel) == j),
      .chain_in  (chain[j]),
      .gt        (gt[j]),
      .chain_out (chain[j+1])
    );
  end

  plbl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .query_go (query_go),
    .n        (n),
    .gt       (gt),
    .status   (status)
  );

  plbl_interp u_interp (
    .clk        (clk),
    .rst_n      (rst_n),
    .go         (status.go),
    .region     (status.region),
    .query_sir  (sir_q_r),
    .entry      (chain[TABLE_DEPTH]),
    .res_valid  (out_valid),
    .res_ber    (out_ber_out),
    .res_region (out_region)
  );

  assign busy      = status.busy;
  assign cfg_ready = !status.busy;

endmodule

// ===== design/plbl_checker.sv =====
// Port-level checks for the lookup core, bound to the top level.
module plbl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        in_kind,
  input logic        out_valid,
  input logic [31:0] out_ber_out,
  input logic [1:0]  out_region
);
  import plbl_pkg::*;

  // A result never exceeds 1.0.
  a_ber_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_ber_out <= BER_ONE)
    else $error("result BER above 1.0");

  // Only the three defined regions are reported.
  a_region_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_region == REGION_ABOVE || out_region == REGION_INTERP ||
                   out_region == REGION_BELOW))
    else $error("undefined region code");

  // An accepted query holds the block busy; a load does not.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_kind == KIND_QUERY) |=> busy)
    else $error("query accepted without going busy");

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_kind == KIND_LOAD) |=> !busy)
    else $error("load left the block busy");

  // A result is shown only once the block is idle again, and never twice in a row.
  a_out_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && $past(busy)) ##1 !out_valid)
    else $error("result strobe out of place");

endmodule

bind piecewise_linear_ber_lookup_core plbl_checker u_plbl_checker (.*);

// ===== tb/testbench.sv =====
// Self-checking testbench for the piecewise-linear BER lookup core.
`timescale 1ns / 100ps

module testbench;
  import plbl_pkg::*;

  // Clock period is 8 ns; reset is held for this many cycles.
  localparam int RESET_CYCLES = 5;
  // Number of random words to send after the directed part.
  localparam int RANDOM_WORDS = 1950;
  // Quiet cycles required after the last answer, so that the block has certainly
  // gone idle before the sender goes on.
  localparam int SETTLE_CYCLES = 48;
  // Cycles without any handshake or answer before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 3000;

  // What one entry of the stimulus plan asks the driver to do.
  typedef enum logic [1:0] {
    ACT_WORD,
    ACT_CFG,
    ACT_DRAIN
  } plan_act_t;

  typedef struct {
    plan_act_t   act;
    logic        kind;
    logic [3:0]  idx;
    logic [31:0] sir;
    logic [31:0] ber;
    logic [31:0] slope;
    logic [4:0]  count;
  } plan_item_t;

  typedef struct packed {
    logic [31:0] ber;
    logic [1:0]  region;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_kind = KIND_LOAD;
  logic [3:0]  in_entry_index = '0;
  logic [31:0] in_sir_value = '0;
  logic [31:0] in_ber_value = '0;
  logic [31:0] in_slope_value = '0;
  logic        out_valid;
  logic [31:0] out_ber_out;
  logic [1:0]  out_region;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_entries_in_use = '0;

  // Words and register writes still to be sent, filled before reset is released.
  plan_item_t pending_words[$];
  // Answers predicted for accepted queries, oldest first.
  answer_t awaited_answers[$];

  // The testbench's own copy of the breakpoint table and the entry count.
  logic [31:0] bp_sir[TABLE_DEPTH];
  logic [31:0] bp_ber[TABLE_DEPTH];
  logic [31:0] bp_slope[TABLE_DEPTH];
  logic [4:0]  bp_count = '0;

  // Planning-time shadow of the table, used to aim queries and to make sure
  // that no query ever reaches an entry that was never loaded.
  logic [31:0]            plan_sir[TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] plan_written = '0;
  int                     words_planned = 0;

  int   queries_sent = 0;
  int   results_seen = 0;
  int   errors = 0;
  int   gap_left = 0;
  int   burst_left = 0;
  int   settle_left = SETTLE_CYCLES;
  int   quiet_cycles = 0;
  logic stimulus_done = 1'b0;

  piecewise_linear_ber_lookup_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_kind            (in_kind),
    .in_entry_index     (in_entry_index),
    .in_sir_value       (in_sir_value),
    .in_ber_value       (in_ber_value),
    .in_slope_value     (in_slope_value),
    .out_valid          (out_valid),
    .out_ber_out        (out_ber_out),
    .out_region         (out_region),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_entries_in_use (cfg_entries_in_use)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction of the lookup.
  // ---------------------------------------------------------------------------

  // A BER is never answered above 1.0.
  function automatic logic [31:0] clamp_ber(logic [63:0] v);
    return (v > {32'd0, BER_ONE}) ? BER_ONE : v[31:0];
  endfunction

  // BER of breakpoint k plus the slope times the SIR shortfall below it. The
  // Q16.16 by Q16.16 product is Q32.32 and one right shift brings it to Q1.31.
  function automatic logic [31:0] interpolate(int k, logic [31:0] sir);
    logic [63:0] drop;
    logic [63:0] scaled;
    drop   = {32'd0, bp_sir[k] - sir};
    scaled = (drop * {32'd0, bp_slope[k]}) >> 1;
    return clamp_ber(scaled + {32'd0, bp_ber[k]});
  endfunction

  // Bisection over the table in the block's own probe order. It only reads
  // entries below the clamped count, so unordered tables behave the same way.
  function automatic answer_t lookup_ber(logic [31:0] sir);
    answer_t ans;
    int      n;
    int      lo;
    int      hi;
    int      mid;
    int      probe;
    bit      done;
    n          = (bp_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(bp_count);
    ans.ber    = BER_ONE;
    ans.region = REGION_BELOW;
    lo         = 0;
    hi         = n;
    done       = 1'b0;
    for (probe = 0; probe <= TABLE_DEPTH && lo < hi && !done; probe++) begin
      mid = (lo + hi) >> 1;
      if (sir > bp_sir[mid]) begin
        if (mid == 0) begin
          ans.ber    = clamp_ber({32'd0, bp_ber[0]});
          ans.region = REGION_ABOVE;
          done       = 1'b1;
        end else if (sir > bp_sir[mid-1]) begin
          hi = mid;
        end else begin
          ans.ber    = interpolate(mid - 1, sir);
          ans.region = REGION_INTERP;
          done       = 1'b1;
        end
      end else if (mid == n - 1) begin
        // At or below the bottom breakpoint: the answer stays 1.0.
        done = 1'b1;
      end else if (sir > bp_sir[mid+1]) begin
        ans.ber    = interpolate(mid, sir);
        ans.region = REGION_INTERP;
        done       = 1'b1;
      end else begin
        lo = mid + 1;
      end
    end
    return ans;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus planning helpers.
  // ---------------------------------------------------------------------------

  task automatic plan_load(int idx, logic [31:0] sir, logic [31:0] ber, logic [31:0] slope);
    plan_item_t item;
    item.act   = ACT_WORD;
    item.kind  = KIND_LOAD;
    item.idx   = idx[3:0];
    item.sir   = sir;
    item.ber   = ber;
    item.slope = slope;
    item.count = '0;
    pending_words.push_back(item);
    plan_sir[idx]     = sir;
    plan_written[idx] = 1'b1;
    words_planned++;
  endtask

  // Load fields that a query never reads are still random, so that every bit
  // of them moves.
  task automatic plan_query(logic [31:0] sir);
    plan_item_t item;
    item.act   = ACT_WORD;
    item.kind  = KIND_QUERY;
    item.idx   = 4'($urandom_range(0, 15));
    item.sir   = sir;
    item.ber   = $urandom;
    item.slope = $urandom;
    item.count = '0;
    pending_words.push_back(item);
    words_planned++;
  endtask

  // Hold the sender until every answer is in and the block has gone quiet.
  task automatic plan_drain();
    plan_item_t item;
    item.act   = ACT_DRAIN;
    item.kind  = KIND_LOAD;
    item.idx   = '0;
    item.sir   = '0;
    item.ber   = '0;
    item.slope = '0;
    item.count = '0;
    pending_words.push_back(item);
  endtask

  // The entry count is only written while the block is idle.
  task automatic plan_config(int count);
    plan_item_t item;
    plan_drain();
    item.act   = ACT_CFG;
    item.kind  = KIND_LOAD;
    item.idx   = '0;
    item.sir   = '0;
    item.ber   = '0;
    item.slope = '0;
    item.count = count[4:0];
    pending_words.push_back(item);
  endtask

  function automatic logic [31:0] pick_ber();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'd0;
    if (r == 1) return BER_ONE;
    if (r <= 4) return $urandom_range(0, BER_ONE);
    return $urandom >> $urandom_range(8, 31);
  endfunction

  function automatic logic [31:0] pick_slope();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'd0;
    if (r == 1) return 32'hFFFF_FFFF;
    return $urandom >> $urandom_range(0, 31);
  endfunction

  // Aim a query at the interesting spots of a table of n entries: on and next
  // to breakpoints, between them, above the top and below the bottom.
  function automatic logic [31:0] pick_sir(int n);
    int          r;
    int          k;
    logic [31:0] lo;
    logic [31:0] hi;
    r = $urandom_range(0, 9);
    if (n == 0 || r == 0) return $urandom;
    if (r == 1) return ($urandom_range(0, 1) == 0) ? 32'd0 : 32'hFFFF_FFFF;
    if (r <= 4) begin
      k = $urandom_range(0, n - 1);
      return plan_sir[k] + 32'($urandom_range(0, 4)) - 32'd2;
    end
    if (r <= 7 && n > 1) begin
      k  = $urandom_range(0, n - 2);
      hi = plan_sir[k];
      lo = plan_sir[k+1];
      if (hi > lo) return lo + $urandom_range(0, hi - lo);
      return $urandom;
    end
    if (r == 8 && plan_sir[0] != 32'hFFFF_FFFF)
      return $urandom_range(plan_sir[0] + 32'd1, 32'hFFFF_FFFF);
    return $urandom_range(0, plan_sir[n-1]);
  endfunction

  // Idle length between words: mostly none or short, a few long, and now and
  // then a burst of back-to-back words.
  function automatic int idle_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      burst_left = $urandom_range(10, 60);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver. It works through the plan one entry at a time. A word stays on the
  // input ports until the block takes it (start high, busy low), and the
  // prediction is made at that same edge from the values then on the ports.
  // Register writes are held until cfg_ready, and a drain entry parks the
  // sender until every predicted answer has come back.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_words
    plan_item_t item;
    logic       word_taken;
    logic       cfg_taken;
    if (!rst_n) begin
      start         <= 1'b0;
      cfg_valid     <= 1'b0;
      stimulus_done <= 1'b0;
    end else begin
      word_taken = start && !busy;
      cfg_taken  = cfg_valid && cfg_ready;
      if (word_taken) begin
        if (in_kind == KIND_QUERY) begin
          awaited_answers.push_back(lookup_ber(in_sir_value));
          queries_sent++;
        end else begin
          bp_sir[in_entry_index]   = in_sir_value;
          bp_ber[in_entry_index]   = in_ber_value;
          bp_slope[in_entry_index] = in_slope_value;
        end
      end
      if (cfg_taken)
        bp_count = cfg_entries_in_use;

      if ((start && !word_taken) || (cfg_valid && !cfg_taken)) begin
        // Still waiting for the block to take the current word or write.
      end else if (gap_left > 0) begin
        gap_left--;
        start     <= 1'b0;
        cfg_valid <= 1'b0;
      end else if (pending_words.size() == 0) begin
        start         <= 1'b0;
        cfg_valid     <= 1'b0;
        stimulus_done <= 1'b1;
      end else begin
        item = pending_words[0];
        case (item.act)
          ACT_WORD: begin
            void'(pending_words.pop_front());
            start          <= 1'b1;
            cfg_valid      <= 1'b0;
            in_kind        <= item.kind;
            in_entry_index <= item.idx;
            in_sir_value   <= item.sir;
            in_ber_value   <= item.ber;
            in_slope_value <= item.slope;
            gap_left        = idle_gap();
          end
          ACT_CFG: begin
            void'(pending_words.pop_front());
            start              <= 1'b0;
            cfg_valid          <= 1'b1;
            cfg_entries_in_use <= item.count;
            gap_left            = idle_gap();
          end
          default: begin
            // results_seen is updated with a nonblocking assignment, so this
            // compare sees the same value whichever block runs first.
            start     <= 1'b0;
            cfg_valid <= 1'b0;
            if (queries_sent != results_seen) begin
              settle_left = SETTLE_CYCLES;
            end else if (settle_left > 0) begin
              settle_left--;
            end else begin
              void'(pending_words.pop_front());
              settle_left = SETTLE_CYCLES;
            end
          end
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. Every answer pulse is matched against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_answers
    answer_t want;
    if (rst_n && out_valid) begin
      if (awaited_answers.size() == 0) begin
        $display("%0t: answer with no query waiting: expected none, got ber %h region %0d",
                 $time, out_ber_out, out_region);
        errors++;
      end else begin
        want = awaited_answers.pop_front();
        results_seen <= results_seen + 1;
        if (out_ber_out !== want.ber) begin
          $display("%0t: ber_out mismatch: expected %h, got %h", $time, want.ber, out_ber_out);
          errors++;
        end
        if (out_region !== want.region) begin
          $display("%0t: region mismatch: expected %0d, got %0d",
                   $time, want.region, out_region);
          errors++;
        end
      end
    end
  end

  // Watchdog: any word, register write or answer counts as progress.
  always @(posedge clk) begin : watchdog
    if (!rst_n || (start && !busy) || (cfg_valid && cfg_ready) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Plan the whole run, release reset, and wait for the driver to finish.
  // ---------------------------------------------------------------------------
  initial begin : plan_and_finish
    int          phase;
    int          n;
    int          style;
    int          k;
    int          queries;
    logic [31:0] cur;
    logic [31:0] span;
    logic [31:0] stride;

    // Empty table straight out of reset: every query answers 1.0 below bottom.
    plan_query(32'h0000_0000);
    plan_query(32'hFFFF_FFFF);

    // A four-entry ordered table with extreme BERs and slopes, plus a write to
    // the last index with every field at its top value.
    plan_load(0, 32'hF000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
    plan_load(1, 32'h8000_0000, 32'h0000_1000, 32'h0001_0000);
    plan_load(2, 32'h0001_0000, 32'h4000_0000, 32'h0000_0001);
    plan_load(3, 32'h0000_0000, BER_ONE, 32'h0000_0000);
    plan_load(15, 32'hFFFF_FFFF, BER_ONE, 32'hFFFF_FFFF);
    plan_config(4);

    // Above the top, exactly on the top, a saturating steep segment, the other
    // segments, on the bottom breakpoint and just above it.
    plan_query(32'hFFFF_FFFF);
    plan_query(32'hF000_0000);
    plan_query(32'hE000_0000);
    plan_query(32'h8000_0001);
    plan_query(32'h4000_0000);
    plan_query(32'h0000_8000);
    plan_query(32'h0000_0000);
    plan_query(32'h0000_0001);

    // Random phases: pick a count, build a table for it (mostly ordered),
    // write the count while idle, then query around the breakpoints with an
    // occasional stray load mixed in.
    phase = 0;
    while (words_planned < 15 + RANDOM_WORDS) begin
      if (phase == 0) n = TABLE_DEPTH;
      else if (phase == 1) n = 0;
      else begin
        k = $urandom_range(0, 9);
        if (k == 0) n = 0;
        else if (k == 1) n = 1;
        else if (k == 2) n = 2;
        else if (k <= 4) n = TABLE_DEPTH;
        else n = $urandom_range(3, TABLE_DEPTH - 1);
      end
      phase++;

      style = $urandom_range(0, 9);
      if (style < 7 && n > 0) begin
        cur  = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom;
        span = cur / n;
        if ($urandom_range(0, 3) == 0) span = $urandom_range(1, 256);
        if (span == 0) span = 1;
        for (k = 0; k < n; k++) begin
          plan_load(k, cur, pick_ber(), pick_slope());
          stride = $urandom_range(1, span);
          cur    = (cur > stride) ? cur - stride : 32'd0;
        end
      end else if (style == 7) begin
        for (k = 0; k < n; k++)
          plan_load(k, $urandom, pick_ber(), pick_slope());
      end else begin
        for (k = 0; k < $urandom_range(0, 3); k++)
          plan_load($urandom_range(0, TABLE_DEPTH - 1), $urandom, pick_ber(), pick_slope());
      end
      // Whatever the style, every entry the count covers has been loaded.
      for (k = 0; k < n; k++)
        if (!plan_written[k])
          plan_load(k, $urandom, pick_ber(), pick_slope());

      plan_config(n);

      queries = $urandom_range(15, 50);
      for (k = 0; k < queries; k++) begin
        if ($urandom_range(0, 15) == 0)
          plan_load($urandom_range(0, TABLE_DEPTH - 1), $urandom, pick_ber(), pick_slope());
        plan_query(pick_sir(n));
      end
    end
    plan_drain();

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    while (!stimulus_done) @(posedge clk);

    if (awaited_answers.size() != 0)
      $display("%0t: %0d predicted answers never arrived", $time, awaited_answers.size());
    if (errors == 0 && awaited_answers.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
